/* hdl/mba_pkg.sv */
// ----------------------------------------------------------------------------
// mba_pkg
// Shared types and constants for the region mosaic block averager.
// ----------------------------------------------------------------------------
package mba_pkg;

  localparam int COORD_BITS = 12;                // region coordinates
  localparam int POS_W      = COORD_BITS + 1;    // block origin on the result side
  localparam int SIZE_W     = 7;                 // block size register and extents
  localparam int MAX_BLOCK  = 64;                // largest block edge
  localparam int SUM_W      = 20;                // per-channel block sum
  localparam int NPIX_W     = 13;                // size*size, up to 4096
  localparam int CHAN_W     = 8;
  localparam int QUO_STEPS  = CHAN_W;            // one quotient bit per step
  localparam int STEP_W     = $clog2(QUO_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic [SIZE_W-1:0] BLOCK_RESET = SIZE_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE = 3'd0,
    REG_START_X    = 3'd1,
    REG_START_Y    = 3'd2,
    REG_END_X      = 3'd3,
    REG_END_Y      = 3'd4
  } reg_index_t;

  // One finished block on its way from the front to the divider.
  typedef struct packed {
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  top;
    logic [SUM_W-1:0]  sum_blue;
    logic [SUM_W-1:0]  sum_green;
    logic [SUM_W-1:0]  sum_red;
    logic [SIZE_W-1:0] write_width;
    logic [SIZE_W-1:0] write_height;
    logic              last;
  } job_t;

endpackage

/* hdl/mba_front.sv */
// ----------------------------------------------------------------------------
// mba_front
// Register file, pixel accumulation and block walk; emits one job per block.
// ----------------------------------------------------------------------------
module mba_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mba_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              accept,
  input  logic [mba_pkg::CHAN_W-1:0]        blue,
  input  logic [mba_pkg::CHAN_W-1:0]        green,
  input  logic [mba_pkg::CHAN_W-1:0]        red,
  output logic                              job_valid,
  output mba_pkg::job_t                     job,
  output logic [mba_pkg::SIZE_W-1:0]        eff_size
);
  import mba_pkg::*;

  logic [SIZE_W-1:0]     block_size;
  logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
  logic [COORD_BITS-1:0] start_x_next, start_y_next;
  logic [SUM_W-1:0]      sum_blue, sum_green, sum_red;
  logic [SUM_W-1:0]      sum_blue_next, sum_green_next, sum_red_next;
  logic [SIZE_W-2:0]     pixel_col, pixel_row;
  logic [POS_W-1:0]      left, top;

  logic [SIZE_W-1:0] size;
  logic [POS_W-1:0]  size_pos, end_x_pos, end_y_pos, next_left, next_top;
  logic [POS_W-1:0]  diff_x, diff_y;
  logic              region_empty, cfg_hit, col_wrap, row_wrap, row_more, col_more;

  assign cfg_ready = 1'b1;
  assign eff_size  = size;

  always_comb begin
    priority if (block_size == '0) size = SIZE_W'(1);
    else if (block_size > SIZE_W'(MAX_BLOCK)) size = SIZE_W'(MAX_BLOCK);
    else size = block_size;
  end

  assign size_pos  = {{(POS_W-SIZE_W){1'b0}}, size};
  assign end_x_pos = {1'b0, end_x};
  assign end_y_pos = {1'b0, end_y};

  // no blocks on an axis once start lies a whole block or more beyond end
  assign region_empty = (end_x_pos + size_pos <= {1'b0, start_x}) ||
                        (end_y_pos + size_pos <= {1'b0, start_y});

  assign col_wrap = ({1'b0, pixel_col} + SIZE_W'(1)) >= size;
  assign row_wrap = ({1'b0, pixel_row} + SIZE_W'(1)) >= size;

  assign sum_blue_next  = sum_blue  + SUM_W'(blue);
  assign sum_green_next = sum_green + SUM_W'(green);
  assign sum_red_next   = sum_red   + SUM_W'(red);

  // blocks walk down a column, then step right
  assign next_top  = top + size_pos;
  assign next_left = left + size_pos;
  assign row_more  = next_top <= end_y_pos;
  assign col_more  = next_left <= end_x_pos;

  assign diff_x = end_x_pos - left;
  assign diff_y = end_y_pos - top;

  assign cfg_hit = (cfg_index == REG_BLOCK_SIZE) || (cfg_index == REG_START_X) ||
                   (cfg_index == REG_START_Y) || (cfg_index == REG_END_X) ||
                   (cfg_index == REG_END_Y);

  assign start_x_next = (cfg_index == REG_START_X) ? cfg_data : start_x;
  assign start_y_next = (cfg_index == REG_START_Y) ? cfg_data : start_y;

  assign job_valid = accept && !(cfg_valid && cfg_hit) && !region_empty &&
                     col_wrap && row_wrap;

  always_comb begin
    job.left      = left;
    job.top       = top;
    job.sum_blue  = sum_blue_next;
    job.sum_green = sum_green_next;
    job.sum_red   = sum_red_next;
    job.last      = !row_more && !col_more;
    if (end_x_pos <= left) job.write_width = '0;
    else if (diff_x >= size_pos) job.write_width = size;
    else job.write_width = diff_x[SIZE_W-1:0];
    if (end_y_pos <= top) job.write_height = '0;
    else if (diff_y >= size_pos) job.write_height = size;
    else job.write_height = diff_y[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_RESET;
      start_x    <= '0;
      start_y    <= '0;
      end_x      <= '0;
      end_y      <= '0;
      sum_blue   <= '0;
      sum_green  <= '0;
      sum_red    <= '0;
      pixel_col  <= '0;
      pixel_row  <= '0;
      left       <= '0;
      top        <= '0;
    end else if (cfg_valid && cfg_hit) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE: block_size <= cfg_data[SIZE_W-1:0];
        REG_START_X:    start_x    <= cfg_data;
        REG_START_Y:    start_y    <= cfg_data;
        REG_END_X:      end_x      <= cfg_data;
        REG_END_Y:      end_y      <= cfg_data;
        default: ;
      endcase
      // any register write restarts the walk
      sum_blue  <= '0;
      sum_green <= '0;
      sum_red   <= '0;
      pixel_col <= '0;
      pixel_row <= '0;
      left      <= {1'b0, start_x_next};
      top       <= {1'b0, start_y_next};
    end else if (accept && !region_empty) begin
      if (!col_wrap) begin
        pixel_col <= pixel_col + 1'b1;
        sum_blue  <= sum_blue_next;
        sum_green <= sum_green_next;
        sum_red   <= sum_red_next;
      end else if (!row_wrap) begin
        pixel_col <= '0;
        pixel_row <= pixel_row + 1'b1;
        sum_blue  <= sum_blue_next;
        sum_green <= sum_green_next;
        sum_red   <= sum_red_next;
      end else begin
        pixel_col <= '0;
        pixel_row <= '0;
        sum_blue  <= '0;
        sum_green <= '0;
        sum_red   <= '0;
        if (row_more) begin
          top <= next_top;
        end else begin
          top <= {1'b0, start_y};
          if (col_more) left <= next_left;
          else left <= {1'b0, start_x};
        end
      end
    end
  end

endmodule

/* hdl/mba_queue.sv */
// ----------------------------------------------------------------------------
// mba_queue
// Short job queue decoupling the front from the divider.
// ----------------------------------------------------------------------------
module mba_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  mba_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output mba_pkg::job_t rd_job,
  output logic          empty
);
  import mba_pkg::*;

  job_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               do_wr, do_rd;

  assign full   = count == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty  = count == '0;
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

/* hdl/mba_back.sv */
// ----------------------------------------------------------------------------
// mba_back
// Bit-serial restoring divider for the three channel means, plus result register.
// ----------------------------------------------------------------------------
module mba_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mba_pkg::SIZE_W-1:0]    eff_size,
  input  logic                          q_empty,
  input  mba_pkg::job_t                 q_job,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [mba_pkg::POS_W-1:0]     block_left,
  output logic [mba_pkg::POS_W-1:0]     block_top,
  output logic [mba_pkg::CHAN_W-1:0]    mean_blue,
  output logic [mba_pkg::CHAN_W-1:0]    mean_green,
  output logic [mba_pkg::CHAN_W-1:0]    mean_red,
  output logic [mba_pkg::SIZE_W-1:0]    write_width,
  output logic [mba_pkg::SIZE_W-1:0]    write_height,
  output logic                          last_block
);
  import mba_pkg::*;

  typedef enum logic [1:0] {IDLE, DIVIDE, HOLD} state_t;

  state_t             state;
  logic [NPIX_W-1:0]  npix;
  logic [SUM_W-1:0]   divisor;
  logic [SUM_W-1:0]   rem_blue, rem_green, rem_red;
  logic [CHAN_W-1:0]  quo_blue, quo_green, quo_red;
  logic [STEP_W-1:0]  step;
  job_t               meta;
  logic               out_valid;
  logic               ge_blue, ge_green, ge_red, out_load;

  assign q_pop    = (state == IDLE) && !q_empty;
  assign ge_blue  = rem_blue  >= divisor;
  assign ge_green = rem_green >= divisor;
  assign ge_red   = rem_red   >= divisor;
  assign out_load = (state == HOLD) && (!out_valid || pop);
  assign empty    = !out_valid;

  // block pixel count, follows the size register
  always_ff @(posedge clk) begin
    npix <= NPIX_W'(eff_size) * NPIX_W'(eff_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            meta      <= q_job;
            rem_blue  <= q_job.sum_blue;
            rem_green <= q_job.sum_green;
            rem_red   <= q_job.sum_red;
            divisor   <= {npix, {(SUM_W-NPIX_W){1'b0}}};
            step      <= STEP_W'(QUO_STEPS-1);
            state     <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (ge_blue)  rem_blue  <= rem_blue  - divisor;
          if (ge_green) rem_green <= rem_green - divisor;
          if (ge_red)   rem_red   <= rem_red   - divisor;
          quo_blue  <= {quo_blue[CHAN_W-2:0], ge_blue};
          quo_green <= {quo_green[CHAN_W-2:0], ge_green};
          quo_red   <= {quo_red[CHAN_W-2:0], ge_red};
          divisor   <= divisor >> 1;
          step      <= step - 1'b1;
          if (step == '0) state <= HOLD;
        end
        HOLD: begin
          if (out_load) state <= IDLE;
        end
        default: state <= IDLE;
      endcase

      if (out_load) begin
        out_valid    <= 1'b1;
        block_left   <= meta.left;
        block_top    <= meta.top;
        mean_blue    <= quo_blue;
        mean_green   <= quo_green;
        mean_red     <= quo_red;
        write_width  <= meta.write_width;
        write_height <= meta.write_height;
        last_block   <= meta.last;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/region_mosaic_block_average_top.sv */
// ----------------------------------------------------------------------------
// region_mosaic_block_average_top
// Block-average mosaic over a rectangular region, one result per block.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle into the front while the job queue has room.
// The divider takes one block at a time (load, 8 quotient steps, hand-off) and
// pops the next job only when idle; hand-off waits while the result register
// holds an unpopped block. A block's job passes in order through the queue, the
// load, the steps and the hand-off. Reset: synchronous; registers return to block
// size 5, all coordinates 0, walk at the first block, queue and result register empty.
// ----------------------------------------------------------------------------
module region_mosaic_block_average_top (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mba_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pixel input
  input  logic                              push,
  output logic                              full,
  input  logic [mba_pkg::CHAN_W-1:0]        blue,
  input  logic [mba_pkg::CHAN_W-1:0]        green,
  input  logic [mba_pkg::CHAN_W-1:0]        red,
  // block results
  output logic                              empty,
  input  logic                              pop,
  output logic [mba_pkg::POS_W-1:0]         block_left,
  output logic [mba_pkg::POS_W-1:0]         block_top,
  output logic [mba_pkg::CHAN_W-1:0]        mean_blue,
  output logic [mba_pkg::CHAN_W-1:0]        mean_green,
  output logic [mba_pkg::CHAN_W-1:0]        mean_red,
  output logic [mba_pkg::SIZE_W-1:0]        write_width,
  output logic [mba_pkg::SIZE_W-1:0]        write_height,
  output logic                              last_block
);
  import mba_pkg::*;

  logic              accept;
  logic              job_valid;
  job_t              job;
  logic              q_full, q_empty, q_pop;
  job_t              q_job;
  logic [SIZE_W-1:0] eff_size;

  // Pixel transfer. Full is raised whenever the queue is full, even for a pixel
  // that would not close a block; this keeps the handshake free of the walk
  // logic. Pixels for an empty region are transferred and dropped.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Front: registers, per-channel sums, pixel and block position counters.
  // Produces a job with the sums, origin, clipped extent and last flag on the
  // transfer of each block's final pixel.
  mba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .job_valid (job_valid),
    .job       (job),
    .eff_size  (eff_size)
  );

  // Two-entry queue between the front and the divider.
  mba_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_job (job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  // Back: shared restoring divider, one quotient bit per cycle for all three
  // channels, then the result register that drives the output queue ports.
  mba_back u_back (
    .clk          (clk),
    .rst          (rst),
    .eff_size     (eff_size),
    .q_empty      (q_empty),
    .q_job        (q_job),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .block_left   (block_left),
    .block_top    (block_top),
    .mean_blue    (mean_blue),
    .mean_green   (mean_green),
    .mean_red     (mean_red),
    .write_width  (write_width),
    .write_height (write_height),
    .last_block   (last_block)
  );

endmodule
